>>> hdl/pulse_rate_meter_defines.svh
// Assertion macros for the pulse rate meter.
// Define NO_ASSERTIONS to compile them out.
`ifndef PULSE_RATE_METER_DEFINES_SVH
`define PULSE_RATE_METER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define PRM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PRM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)

`define PRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> hdl/prm_pkg.sv
package prm_pkg;

    // default parameter values
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int RATE_WIDTH_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    // fixed field widths
    localparam int TPM_WIDTH   = 32;
    localparam int FLAT_WIDTH  = 32;
    localparam int THR_WIDTH   = 10;
    localparam int BPM_WIDTH   = 16;
    localparam int DIGIT_WIDTH = 4;
    localparam int NUM_DIGITS  = 3;

    // configuration port
    localparam int ADDR_WIDTH = 4;
    localparam int DATA_WIDTH = 32;

    localparam logic [1:0] REG_TICKS_PER_MINUTE = 2'd0;
    localparam logic [1:0] REG_FLATLINE_TICKS   = 2'd1;
    localparam logic [1:0] REG_ALARM_BPM        = 2'd2;

    localparam logic [TPM_WIDTH-1:0]  TPM_RESET  = 32'd360000000;
    localparam logic [FLAT_WIDTH-1:0] FLAT_RESET = 32'd18000000;
    localparam logic [THR_WIDTH-1:0]  THR_RESET  = 10'd250;

    // event kinds
    localparam logic EVT_PERIOD   = 1'b0;
    localparam logic EVT_FLATLINE = 1'b1;

    // iterative units
    localparam int DIV_STEPS = TPM_WIDTH;
    localparam int BCD_STEPS = BPM_WIDTH;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [TPM_WIDTH-1:0]  ticks_per_minute;
        logic [FLAT_WIDTH-1:0] flatline_ticks;
        logic [THR_WIDTH-1:0]  alarm_bpm;
    } t_cfg;

    typedef enum logic [1:0] {
        PH_WAIT_LOW,
        PH_WAIT_RISE,
        PH_HIGH,
        PH_LOW
    } t_phase;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_BCD,
        BK_HOLD
    } t_back_state;

endpackage

>>> hdl/prm_front.sv
module prm_front #(
    parameter int COUNT_WIDTH = prm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              i_level,
    input  logic [prm_pkg::FLAT_WIDTH-1:0]    i_flatline_ticks,
    output logic                              o_req_push,
    output logic                              o_req_kind,
    output logic [COUNT_WIDTH-1:0]            o_req_ticks
);

    localparam int CMP_W = (COUNT_WIDTH > prm_pkg::FLAT_WIDTH) ?
                           COUNT_WIDTH : prm_pkg::FLAT_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    prm_pkg::t_phase        r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [COUNT_WIDTH-1:0] bumped;
    logic                   flat_hit;

    assign bumped   = (r_count == COUNT_MAX) ? r_count : r_count + COUNT_WIDTH'(1);
    assign flat_hit = (CMP_W'(bumped) >= CMP_W'(i_flatline_ticks)) || (bumped == COUNT_MAX);

    // next state
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            prm_pkg::PH_WAIT_LOW: begin
                if (!i_level) n_phase = prm_pkg::PH_WAIT_RISE;
            end
            prm_pkg::PH_WAIT_RISE: begin
                if (i_level) n_phase = prm_pkg::PH_HIGH;
                else if (flat_hit) n_phase = prm_pkg::PH_WAIT_LOW;
            end
            prm_pkg::PH_HIGH: begin
                if (!i_level) n_phase = prm_pkg::PH_LOW;
            end
            prm_pkg::PH_LOW: begin
                if (i_level) n_phase = prm_pkg::PH_WAIT_LOW;
            end
        endcase
    end

    // counter and requests
    always_comb begin
        n_count     = r_count;
        o_req_push  = 1'b0;
        o_req_kind  = prm_pkg::EVT_PERIOD;
        o_req_ticks = bumped;
        unique case (r_phase)
            prm_pkg::PH_WAIT_LOW: begin
                n_count = '0;
            end
            prm_pkg::PH_WAIT_RISE: begin
                if (i_level || flat_hit) n_count = '0;
                else n_count = bumped;
                if (!i_level && flat_hit) begin
                    o_req_push = i_valid;
                    o_req_kind = prm_pkg::EVT_FLATLINE;
                end
            end
            prm_pkg::PH_HIGH: begin
                n_count = bumped;
            end
            prm_pkg::PH_LOW: begin
                if (i_level) begin
                    n_count    = '0;
                    o_req_push = i_valid;
                end else begin
                    n_count = bumped;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= prm_pkg::PH_WAIT_LOW;
            r_count <= '0;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

endmodule

>>> hdl/prm_queue.sv
`include "pulse_rate_meter_defines.svh"

module prm_queue #(
    parameter int WIDTH = 33,
    parameter int DEPTH = prm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            if (do_pop)  r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            if (do_push && !do_pop)      r_count <= r_count + CNT_W'(1);
            else if (do_pop && !do_push) r_count <= r_count - CNT_W'(1);
        end
    end

    `PRM_ASSERT_IMPL(a_q_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH), "queue overfilled")
    `PRM_ASSERT_NEXT(a_q_fill, i_clk, i_rst_n, i_rst_n && i_push && !i_pop, r_count == $past(r_count) + CNT_W'(1), "request lost")

endmodule

>>> hdl/prm_back.sv
`include "pulse_rate_meter_defines.svh"

module prm_back #(
    parameter int COUNT_WIDTH = prm_pkg::COUNT_WIDTH_DEF,
    parameter int RATE_WIDTH  = prm_pkg::RATE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  prm_pkg::t_cfg                       i_cfg,
    input  logic                                i_q_empty,
    input  logic [COUNT_WIDTH:0]                i_q_data,
    output logic                                o_q_pop,
    input  logic                                i_pop,
    output logic                                o_empty,
    output logic                                o_event_kind,
    output logic [prm_pkg::BPM_WIDTH-1:0]       o_beats_per_minute,
    output logic                                o_alarm,
    output logic                                o_first_alarm,
    output logic [prm_pkg::DIGIT_WIDTH-1:0]     o_digit_hundreds,
    output logic [prm_pkg::DIGIT_WIDTH-1:0]     o_digit_tens,
    output logic [prm_pkg::DIGIT_WIDTH-1:0]     o_digit_units,
    output logic                                o_led_on
);

    localparam int QW = prm_pkg::TPM_WIDTH;
    localparam int BW = prm_pkg::BPM_WIDTH;
    localparam int DW = prm_pkg::DIGIT_WIDTH * prm_pkg::NUM_DIGITS;
    localparam int SW = prm_pkg::STEP_W;
    localparam logic [QW-1:0] BPM_CAP = (RATE_WIDTH < BW) ?
        QW'((64'd1 << RATE_WIDTH) - 64'd1) : QW'((64'd1 << BW) - 64'd1);

    prm_pkg::t_back_state r_state, n_state;
    logic [SW-1:0]          r_step, n_step;
    logic [COUNT_WIDTH-1:0] r_rem, n_rem, r_div, n_div;
    logic [QW-1:0]          r_quo, n_quo;
    logic [BW-1:0]          r_bpm, n_bpm, r_bin, n_bin;
    logic [DW-1:0]          r_bcd, n_bcd;
    logic                   r_kind, n_kind;
    logic                   r_alarm_reported;
    logic                   r_out_valid;

    logic [COUNT_WIDTH:0]   shifted;
    logic                   qbit;
    logic [QW-1:0]          q_final, q_sat;
    logic [DW-1:0]          bcd_adj;
    logic                   load_out, last_div, last_bcd;
    logic                   res_alarm, res_led;
    logic [DW-1:0]          res_digits;

    // one restoring division step
    assign shifted  = {r_rem, r_quo[QW-1]};
    assign qbit     = (shifted >= {1'b0, r_div});
    assign q_final  = {r_quo[QW-2:0], qbit};
    assign q_sat    = (q_final > BPM_CAP) ? BPM_CAP : q_final;
    assign last_div = (r_step == SW'(prm_pkg::DIV_STEPS - 1));
    assign last_bcd = (r_step == SW'(prm_pkg::BCD_STEPS - 1));
    assign load_out = (r_state == prm_pkg::BK_HOLD) && (!r_out_valid || i_pop);

    always_comb begin
        for (int i = 0; i < prm_pkg::NUM_DIGITS; i++) begin
            bcd_adj[i*prm_pkg::DIGIT_WIDTH +: prm_pkg::DIGIT_WIDTH] =
                (r_bcd[i*prm_pkg::DIGIT_WIDTH +: prm_pkg::DIGIT_WIDTH] >= 4'd5) ?
                r_bcd[i*prm_pkg::DIGIT_WIDTH +: prm_pkg::DIGIT_WIDTH] + 4'd3 :
                r_bcd[i*prm_pkg::DIGIT_WIDTH +: prm_pkg::DIGIT_WIDTH];
        end
    end

    // result fields
    assign res_alarm  = (r_kind == prm_pkg::EVT_PERIOD) &&
                        (r_bpm > BW'(i_cfg.alarm_bpm));
    assign res_led    = (r_kind == prm_pkg::EVT_PERIOD) && !res_alarm;
    assign res_digits = res_led ? r_bcd : '0;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            prm_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    n_state = (i_q_data[COUNT_WIDTH] == prm_pkg::EVT_FLATLINE) ?
                              prm_pkg::BK_HOLD : prm_pkg::BK_DIV;
                end
            end
            prm_pkg::BK_DIV: begin
                if (last_div) n_state = prm_pkg::BK_BCD;
            end
            prm_pkg::BK_BCD: begin
                if (last_bcd) n_state = prm_pkg::BK_HOLD;
            end
            prm_pkg::BK_HOLD: begin
                if (load_out) n_state = prm_pkg::BK_IDLE;
            end
        endcase
    end

    // datapath
    always_comb begin
        o_q_pop = 1'b0;
        n_step  = r_step;
        n_rem   = r_rem;
        n_div   = r_div;
        n_quo   = r_quo;
        n_bpm   = r_bpm;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_kind  = r_kind;
        unique case (r_state)
            prm_pkg::BK_IDLE: begin
                o_q_pop = !i_q_empty;
                n_kind  = i_q_data[COUNT_WIDTH];
                n_div   = i_q_data[COUNT_WIDTH-1:0];
                n_quo   = i_cfg.ticks_per_minute;
                n_rem   = '0;
                n_step  = '0;
                n_bpm   = '0;
                n_bcd   = '0;
            end
            prm_pkg::BK_DIV: begin
                n_rem  = qbit ? COUNT_WIDTH'(shifted - {1'b0, r_div}) :
                                shifted[COUNT_WIDTH-1:0];
                n_quo  = q_final;
                n_step = last_div ? '0 : r_step + SW'(1);
                if (last_div) begin
                    n_bpm = BW'(q_sat);
                    n_bin = BW'(q_sat);
                    n_bcd = '0;
                end
            end
            prm_pkg::BK_BCD: begin
                // double dabble, kept to three digits: rate modulo 1000
                n_bcd  = {bcd_adj[DW-2:0], r_bin[BW-1]};
                n_bin  = {r_bin[BW-2:0], 1'b0};
                n_step = r_step + SW'(1);
            end
            prm_pkg::BK_HOLD: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_quo  <= n_quo;
        r_bpm  <= n_bpm;
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_kind <= n_kind;
        if (load_out) begin
            o_event_kind       <= r_kind;
            o_beats_per_minute <= r_bpm;
            o_alarm            <= res_alarm;
            o_first_alarm      <= res_alarm && !r_alarm_reported;
            o_digit_hundreds   <= res_digits[11:8];
            o_digit_tens       <= res_digits[7:4];
            o_digit_units      <= res_digits[3:0];
            o_led_on           <= res_led;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= prm_pkg::BK_IDLE;
            r_step           <= '0;
            r_alarm_reported <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (load_out && res_alarm) r_alarm_reported <= 1'b1;
            if (load_out) r_out_valid <= 1'b1;
            else if (i_pop) r_out_valid <= 1'b0;
        end
    end

    assign o_empty = !r_out_valid;

    `PRM_ASSERT_NEXT(a_bk_load, i_clk, i_rst_n, i_rst_n && load_out, !o_empty, "result not shown")
    `PRM_ASSERT_IMPL(a_bk_flat, i_clk, i_rst_n, !o_empty && o_event_kind, o_beats_per_minute == '0 && !o_led_on && !o_alarm, "bad flatline result")
    `PRM_ASSERT_IMPL(a_bk_alarm, i_clk, i_rst_n, !o_empty && o_alarm, !o_led_on && o_digit_units == '0 && o_digit_tens == '0 && o_digit_hundreds == '0, "bad alarm result")
    `PRM_ASSERT_IMPL(a_bk_first, i_clk, i_rst_n, !o_empty && o_first_alarm, o_alarm, "first alarm without alarm")

endmodule

>>> hdl/pulse_rate_meter.sv
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+--------------------------------------------
// sample   | in        | push / full          | i_pulse_level
// result   | out       | pop / empty          | o_event_kind, o_beats_per_minute, o_alarm,
//          |           |                      | o_first_alarm, o_digit_*, o_led_on
// config   | in/out    | psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
// One sample is taken per cycle while push is high and full is low; full rises
// only when the request queue is full. A beat request is popped, then takes 32
// bit-serial divider steps and 16 binary-to-decimal steps; a flatline skips both.
// A result waits in the output register until popped; the back end stalls in hold.
// Synchronous active-low reset; config writes are assumed only while idle.

module pulse_rate_meter #(
    parameter int COUNT_WIDTH = prm_pkg::COUNT_WIDTH_DEF,
    parameter int RATE_WIDTH  = prm_pkg::RATE_WIDTH_DEF,
    parameter int QUEUE_DEPTH = prm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample channel
    input  logic                                push,
    output logic                                full,
    input  logic                                i_pulse_level,
    // result channel
    input  logic                                pop,
    output logic                                empty,
    output logic                                o_event_kind,
    output logic [prm_pkg::BPM_WIDTH-1:0]       o_beats_per_minute,
    output logic                                o_alarm,
    output logic                                o_first_alarm,
    output logic [prm_pkg::DIGIT_WIDTH-1:0]     o_digit_hundreds,
    output logic [prm_pkg::DIGIT_WIDTH-1:0]     o_digit_tens,
    output logic [prm_pkg::DIGIT_WIDTH-1:0]     o_digit_units,
    output logic                                o_led_on,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [prm_pkg::ADDR_WIDTH-1:0]      paddr,
    input  logic [prm_pkg::DATA_WIDTH-1:0]      pwdata,
    output logic [prm_pkg::DATA_WIDTH-1:0]      prdata,
    output logic                                pready
);

    prm_pkg::t_cfg          r_cfg;
    logic                   cfg_wr;
    logic                   sample_acc;
    logic                   req_push, req_kind;
    logic [COUNT_WIDTH-1:0] req_ticks;
    logic                   q_full, q_empty, q_pop;
    logic [COUNT_WIDTH:0]   q_data;

    // ------------------------------------------------------------------
    // Register file: word address in paddr[3:2], unknown index ignored.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_minute <= prm_pkg::TPM_RESET;
            r_cfg.flatline_ticks   <= prm_pkg::FLAT_RESET;
            r_cfg.alarm_bpm        <= prm_pkg::THR_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                prm_pkg::REG_TICKS_PER_MINUTE: r_cfg.ticks_per_minute <= pwdata;
                prm_pkg::REG_FLATLINE_TICKS:   r_cfg.flatline_ticks   <= pwdata;
                prm_pkg::REG_ALARM_BPM:
                    r_cfg.alarm_bpm <= pwdata[prm_pkg::THR_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            prm_pkg::REG_TICKS_PER_MINUTE: prdata = r_cfg.ticks_per_minute;
            prm_pkg::REG_FLATLINE_TICKS:   prdata = r_cfg.flatline_ticks;
            prm_pkg::REG_ALARM_BPM:
                prdata = prm_pkg::DATA_WIDTH'(r_cfg.alarm_bpm);
            default:                       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Front end: edge tracking and period counting, one sample a cycle
    // while push is high and full is low; a period or flatline is queued.
    // ------------------------------------------------------------------
    assign full       = q_full;
    assign sample_acc = push && !full;

    prm_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (sample_acc),
        .i_level          (i_pulse_level),
        .i_flatline_ticks (r_cfg.flatline_ticks),
        .o_req_push       (req_push),
        .o_req_kind       (req_kind),
        .o_req_ticks      (req_ticks)
    );

    // short request queue: lets sampling run on while the divider is busy
    prm_queue #(
        .WIDTH (COUNT_WIDTH + 1),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (req_push),
        .i_data  ({req_kind, req_ticks}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    // ------------------------------------------------------------------
    // Back end: divide, saturate, classify, convert to digits, hold.
    // ------------------------------------------------------------------
    prm_back #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .RATE_WIDTH  (RATE_WIDTH)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_q_empty          (q_empty),
        .i_q_data           (q_data),
        .o_q_pop            (q_pop),
        .i_pop              (pop),
        .o_empty            (empty),
        .o_event_kind       (o_event_kind),
        .o_beats_per_minute (o_beats_per_minute),
        .o_alarm            (o_alarm),
        .o_first_alarm      (o_first_alarm),
        .o_digit_hundreds   (o_digit_hundreds),
        .o_digit_tens       (o_digit_tens),
        .o_digit_units      (o_digit_units),
        .o_led_on           (o_led_on)
    );

endmodule
